// ===== rtl/mpc_pkg.sv =====
// Shared types, constants and helpers for the moisture pump controller.
// Used by every module in rtl/ but mpc_checker; depends on nothing else.
package mpc_pkg;

  localparam int ADC_MAX_CODE = 4095;

  localparam logic [9:0] MOIST_FULL = 10'd1000;
  localparam logic [3:0] DIV_STEPS  = 4'd10;

  // Configuration register indexes (byte address is 4 * index).
  typedef enum logic [2:0] {
    REG_AUTOMATION_ENABLE = 3'd0,
    REG_MOISTURE_TARGET   = 3'd1,
    REG_HYSTERESIS_BAND   = 3'd2,
    REG_MAX_RUN_SECONDS   = 3'd3,
    REG_COOLDOWN_SECONDS  = 3'd4,
    REG_RAW_DRY_LEVEL     = 3'd5,
    REG_RAW_WET_LEVEL     = 3'd6,
    REG_BATTERY_BLOCK_MV  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    REQ_TICK       = 2'd0,
    REQ_MANUAL_ON  = 2'd1,
    REQ_MANUAL_OFF = 2'd2
  } req_t;

  typedef struct packed {
    logic        automation_enable;
    logic [9:0]  moisture_target;
    logic [7:0]  hysteresis_band;
    logic [5:0]  max_run_seconds;
    logic [7:0]  cooldown_seconds;
    logic [11:0] raw_dry_level;
    logic [11:0] raw_wet_level;
    logic [12:0] battery_block_mv;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    automation_enable: 1'b1,
    moisture_target:   10'd550,
    hysteresis_band:   8'd30,
    max_run_seconds:   6'd18,
    cooldown_seconds:  8'd25,
    raw_dry_level:     12'd3000,
    raw_wet_level:     12'd1200,
    battery_block_mv:  13'd4720
  };

  typedef struct packed {
    logic        start;
    logic [11:0] num;
    logic [11:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [9:0] quot;
  } div_rsp_t;

  // x * 1000 as x * 1024 - x * 16 - x * 8.
  function automatic logic [21:0] times_1000(input logic [11:0] x);
    times_1000 = {x, 10'b0} - {6'b0, x, 4'b0} - {7'b0, x, 3'b0};
  endfunction

endpackage

// ===== rtl/mpc_cfg_regs.sv =====
// APB-style configuration register file for the moisture pump controller.
// Depends on mpc_pkg for the register map and the cfg_t bundle.
module mpc_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mpc_pkg::cfg_t      cfg
);
  import mpc_pkg::*;

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_AUTOMATION_ENABLE: regs.automation_enable <= pwdata[0];
        REG_MOISTURE_TARGET:   regs.moisture_target   <= pwdata[9:0];
        REG_HYSTERESIS_BAND:   regs.hysteresis_band   <= pwdata[7:0];
        REG_MAX_RUN_SECONDS:   regs.max_run_seconds   <= pwdata[5:0];
        REG_COOLDOWN_SECONDS:  regs.cooldown_seconds  <= pwdata[7:0];
        REG_RAW_DRY_LEVEL:     regs.raw_dry_level     <= pwdata[11:0];
        REG_RAW_WET_LEVEL:     regs.raw_wet_level     <= pwdata[11:0];
        REG_BATTERY_BLOCK_MV:  regs.battery_block_mv  <= pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AUTOMATION_ENABLE: prdata = {31'b0, regs.automation_enable};
      REG_MOISTURE_TARGET:   prdata = {22'b0, regs.moisture_target};
      REG_HYSTERESIS_BAND:   prdata = {24'b0, regs.hysteresis_band};
      REG_MAX_RUN_SECONDS:   prdata = {26'b0, regs.max_run_seconds};
      REG_COOLDOWN_SECONDS:  prdata = {24'b0, regs.cooldown_seconds};
      REG_RAW_DRY_LEVEL:     prdata = {20'b0, regs.raw_dry_level};
      REG_RAW_WET_LEVEL:     prdata = {20'b0, regs.raw_wet_level};
      REG_BATTERY_BLOCK_MV:  prdata = {19'b0, regs.battery_block_mv};
    endcase
  end

endmodule

// ===== rtl/mpc_divider.sv =====
// Iterative restoring divider: quotient of num * 1000 / den, one bit a cycle.
// Depends on mpc_pkg; the caller guarantees num < den, so the quotient fits 10 bits.
module mpc_divider (
  input  logic              clk,
  input  logic              rst,
  input  mpc_pkg::div_req_t req,
  output mpc_pkg::div_rsp_t rsp
);
  import mpc_pkg::*;

  logic [11:0] rem;
  logic [9:0]  acc;
  logic [11:0] den_q;
  logic [3:0]  cnt;
  logic        done;
  logic [21:0] dividend;
  logic [12:0] trial;
  logic [12:0] diff;
  logic        fits;

  assign dividend = times_1000(req.num);
  assign trial    = {rem, acc[9]};
  assign diff     = trial - {1'b0, den_q};
  assign fits     = trial >= {1'b0, den_q};

  // The dividend is below den * 1024, so its upper 12 bits already sit below
  // den and only the low 10 quotient bits need steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= DIV_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= dividend[21:10];
      acc   <= dividend[9:0];
      den_q <= req.den;
    end else if (cnt != '0) begin
      rem <= fits ? diff[11:0] : trial[11:0];
      acc <= {acc[8:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = acc;

endmodule

// ===== rtl/mpc_ctrl.sv =====
// Sequencer of the moisture pump controller: calibration setup, timer update,
// start decision and the output register. Depends on mpc_pkg and mpc_divider.
module mpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  mpc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [15:0]       elapsed_ms,
  input  logic [11:0]       moisture_raw,
  input  logic [12:0]       battery_mv,
  input  logic              second_mark,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              pump_on,
  output logic [9:0]        moisture_tenths,
  output logic              start_blocked,
  output logic [15:0]       run_time_left,
  output logic [17:0]       cooldown_time_left,
  output logic [31:0]       pump_starts,
  output logic [31:0]       pump_on_seconds,
  output mpc_pkg::div_req_t div_req,
  input  mpc_pkg::div_rsp_t div_rsp
);
  import mpc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CALIB  = 6'b000010,
    S_DIVIDE = 6'b000100,
    S_TIMERS = 6'b001000,
    S_DECIDE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t      state;
  req_t        req_q;
  logic [15:0] dt_q;
  logic [11:0] raw_q;
  logic [12:0] batt_q;
  logic        mark_q;
  logic [9:0]  moist;
  logic        blocked;

  logic        pump_running;
  logic [15:0] run_left;
  logic [17:0] cooldown_left;
  logic [31:0] start_count;
  logic [31:0] on_second_count;

  logic [11:0] raw_sat;
  logic [11:0] num;
  logic [11:0] den;
  logic        need_div;
  logic [9:0]  calib_moist;

  logic [21:0] run_load_full;
  logic [21:0] cool_load_full;
  logic [15:0] run_load;
  logic [17:0] cool_load;
  logic [17:0] cool_dec;
  logic [15:0] run_dec;
  logic        run_expired;
  logic [10:0] moist_plus_band;
  logic        want_start;
  logic        low_batt;
  logic        pump_after;
  logic [31:0] start_inc;
  logic        out_load;

  assign in_ready = (state == S_IDLE);

  // Calibration setup: the special cases resolve here, the rest divides.
  always_comb begin
    raw_sat     = (raw_q > 12'(ADC_MAX_CODE)) ? 12'(ADC_MAX_CODE) : raw_q;
    num         = '0;
    den         = '0;
    need_div    = 1'b0;
    calib_moist = '0;
    if (cfg.raw_dry_level > cfg.raw_wet_level) begin
      if (raw_sat < cfg.raw_dry_level) begin
        num = cfg.raw_dry_level - raw_sat;
        den = cfg.raw_dry_level - cfg.raw_wet_level;
      end
    end else if (cfg.raw_dry_level < cfg.raw_wet_level) begin
      if (raw_sat > cfg.raw_dry_level) begin
        num = raw_sat - cfg.raw_dry_level;
        den = cfg.raw_wet_level - cfg.raw_dry_level;
      end
    end else begin
      calib_moist = (raw_sat > cfg.raw_dry_level) ? MOIST_FULL : 10'd0;
    end
    if (den != '0) begin
      if (num >= den) begin
        calib_moist = MOIST_FULL;
      end else begin
        need_div = 1'b1;
      end
    end
  end

  assign div_req.start = (state == S_CALIB) && need_div;
  assign div_req.num   = num;
  assign div_req.den   = den;

  assign run_load_full  = times_1000({6'b0, cfg.max_run_seconds});
  assign cool_load_full = times_1000({4'b0, cfg.cooldown_seconds});
  assign run_load       = run_load_full[15:0];
  assign cool_load      = cool_load_full[17:0];

  assign cool_dec    = ({2'b0, dt_q} >= cooldown_left) ? 18'd0
                                                       : cooldown_left - {2'b0, dt_q};
  assign run_dec     = (dt_q >= run_left) ? 16'd0 : run_left - dt_q;
  assign run_expired = (run_left != '0) && (dt_q >= run_left);

  // moist < target - band, rearranged so no signed value is needed.
  assign moist_plus_band = {1'b0, moist} + {3'b0, cfg.hysteresis_band};
  assign want_start = cfg.automation_enable && !pump_running && (cooldown_left == '0)
                      && (moist_plus_band < {1'b0, cfg.moisture_target});
  assign low_batt   = batt_q < cfg.battery_block_mv;
  assign pump_after = pump_running || (want_start && !low_batt);
  assign start_inc  = start_count + 32'd1;

  // The result register loads when it is empty or drains in the same cycle.
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pump_running    <= 1'b0;
      run_left        <= '0;
      cooldown_left   <= '0;
      start_count     <= '0;
      on_second_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (req_t'(req_type) == REQ_TICK) ? S_CALIB : S_TIMERS;
          end
        end
        S_CALIB: begin
          state <= need_div ? S_DIVIDE : S_TIMERS;
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            state <= S_TIMERS;
          end
        end
        S_TIMERS: begin
          case (req_q)
            REQ_TICK: begin
              run_left <= run_dec;
              if (run_expired) begin
                pump_running  <= 1'b0;
                cooldown_left <= cool_load;
              end else begin
                cooldown_left <= cool_dec;
              end
            end
            REQ_MANUAL_ON: begin
              run_left      <= run_load;
              cooldown_left <= '0;
              if (!pump_running) begin
                pump_running <= 1'b1;
                start_count  <= start_inc;
              end
            end
            REQ_MANUAL_OFF: begin
              run_left      <= '0;
              pump_running  <= 1'b0;
              cooldown_left <= cool_load;
            end
            default: begin
            end
          endcase
          state <= (req_q == REQ_TICK) ? S_DECIDE : S_FINISH;
        end
        S_DECIDE: begin
          if (want_start && !low_batt) begin
            run_left     <= run_load;
            pump_running <= 1'b1;
            start_count  <= start_inc;
          end
          if (mark_q && pump_after) begin
            on_second_count <= on_second_count + 32'd1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload and per-item results.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_q   <= req_t'(req_type);
          dt_q    <= elapsed_ms;
          raw_q   <= moisture_raw;
          batt_q  <= battery_mv;
          mark_q  <= second_mark;
          moist   <= '0;
          blocked <= 1'b0;
        end
      end
      S_CALIB: begin
        if (!need_div) begin
          moist <= calib_moist;
        end
      end
      S_DIVIDE: begin
        if (div_rsp.done) begin
          moist <= div_rsp.quot;
        end
      end
      S_DECIDE: begin
        if (want_start && low_batt) begin
          blocked <= 1'b1;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          pump_on            <= pump_running;
          moisture_tenths    <= moist;
          start_blocked      <= blocked;
          run_time_left      <= run_left;
          cooldown_time_left <= cooldown_left;
          pump_starts        <= start_count;
          pump_on_seconds    <= on_second_count;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/moisture_pump_controller_top.sv =====
// Top level of the moisture pump controller: register file, sequencer, divider.
// Depends on mpc_pkg, mpc_cfg_regs, mpc_divider and mpc_ctrl.
//
//   Channel  Handshake              Beat carries
//   in       in_valid / in_ready    req_type, elapsed_ms, moisture_raw, battery_mv, second_mark
//   out      out_valid / out_ready  pump_on, moisture_tenths, start_blocked, run_time_left,
//                                   cooldown_time_left, pump_starts, pump_on_seconds
//   cfg      psel / penable / pready  paddr, pwdata, pwrite, prdata
//
// A tick that divides goes from acceptance to a result beat through the setup step, the
// bit-serial divider (ten steps and a hand-back of the quotient), the timer step, the decision
// step and the output load. Ticks whose calibration needs no division skip the divider;
// manual commands go straight from acceptance to the timer step and the output load.
// in_ready is high only between items, from the cycle after the output load.
// A result beat may wait in the output register while the next item is accepted, and the
// sequencer holds its last step until it drains.
// Synchronous reset restores register defaults and clears pump state, timers and counters.
module moisture_pump_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] elapsed_ms,
  input  logic [11:0] moisture_raw,
  input  logic [12:0] battery_mv,
  input  logic        second_mark,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pump_on,
  output logic [9:0]  moisture_tenths,
  output logic        start_blocked,
  output logic [15:0] run_time_left,
  output logic [17:0] cooldown_time_left,
  output logic [31:0] pump_starts,
  output logic [31:0] pump_on_seconds,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpc_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  mpc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  mpc_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .req_type           (req_type),
    .elapsed_ms         (elapsed_ms),
    .moisture_raw       (moisture_raw),
    .battery_mv         (battery_mv),
    .second_mark        (second_mark),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .pump_on            (pump_on),
    .moisture_tenths    (moisture_tenths),
    .start_blocked      (start_blocked),
    .run_time_left      (run_time_left),
    .cooldown_time_left (cooldown_time_left),
    .pump_starts        (pump_starts),
    .pump_on_seconds    (pump_on_seconds),
    .div_req            (div_req),
    .div_rsp            (div_rsp)
  );

endmodule

// ===== rtl/mpc_checker.sv =====
// Port-level checks for the moisture pump controller, bound to the top level.
// Depends only on the top level's port names.
module mpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pump_on,
  input logic        start_blocked,
  input logic [15:0] run_time_left,
  input logic [17:0] cooldown_time_left,
  input logic [31:0] pump_starts
);

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // Run time is only ever loaded when the pump is turned on or kept on.
  a_run_implies_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_time_left != 16'd0 |-> pump_on)
    else $error("run time left while the pump is off");

  // Cooldown is zero at every start and stays zero while pumping.
  a_cooldown_implies_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && cooldown_time_left != 18'd0 |-> !pump_on)
    else $error("cooldown pending while the pump is on");

  a_blocked_implies_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_blocked |-> !pump_on)
    else $error("start reported blocked but the pump is on");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pump_starts))
    else $error("result beat dropped or changed while stalled");

endmodule

bind moisture_pump_controller_top mpc_checker u_mpc_checker (.*);

// ===== tb/tb_moisture_pump_controller_top.sv =====
// Self-checking testbench for moisture_pump_controller_top: drives request beats, writes the
// registers over APB between phases and checks every result beat against a local predictor.
// Depends on mpc_pkg and the RTL top level only.
module tb_moisture_pump_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpc_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD   = 300;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] dt;
    logic [11:0] raw;
    logic [12:0] batt;
    logic        mark;
  } ctrl_item_t;

  typedef struct packed {
    logic        pump;
    logic [9:0]  moist;
    logic        blocked;
    logic [15:0] run_left;
    logic [17:0] cool_left;
    logic [31:0] starts;
    logic [31:0] on_secs;
  } ctrl_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [15:0] elapsed_ms = '0;
  logic [11:0] moisture_raw = '0;
  logic [12:0] battery_mv = '0;
  logic        second_mark = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        pump_on;
  logic [9:0]  moisture_tenths;
  logic        start_blocked;
  logic [15:0] run_time_left;
  logic [17:0] cooldown_time_left;
  logic [31:0] pump_starts;
  logic [31:0] pump_on_seconds;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  moisture_pump_controller_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .elapsed_ms(elapsed_ms), .moisture_raw(moisture_raw),
    .battery_mv(battery_mv), .second_mark(second_mark),
    .out_valid(out_valid), .out_ready(out_ready),
    .pump_on(pump_on), .moisture_tenths(moisture_tenths), .start_blocked(start_blocked),
    .run_time_left(run_time_left), .cooldown_time_left(cooldown_time_left),
    .pump_starts(pump_starts), .pump_on_seconds(pump_on_seconds),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state: a copy of the registers and of the pump state.
  cfg_t        live_cfg = CFG_RESET;
  bit          pump_state = 1'b0;
  int unsigned run_ms = 0;
  int unsigned cool_ms = 0;
  bit [31:0]   start_total = '0;
  bit [31:0]   on_second_total = '0;

  ctrl_item_t   item_backlog[$];
  ctrl_status_t status_due[$];
  ctrl_item_t   launch_item;

  int unsigned error_count = 0;
  int unsigned beats_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          backpressure_done = 1'b0;
  logic        in_beat_taken = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] tenths_from_raw(input logic [11:0] raw);
    int unsigned r, dry, wet, num, den;
    r   = (raw > ADC_MAX_CODE) ? ADC_MAX_CODE : raw;
    dry = live_cfg.raw_dry_level;
    wet = live_cfg.raw_wet_level;
    if (dry > wet) begin
      if (r >= dry) return '0;
      num = dry - r;
      den = dry - wet;
    end else if (dry < wet) begin
      if (r <= dry) return '0;
      num = r - dry;
      den = wet - dry;
    end else begin
      return (r > dry) ? MOIST_FULL : '0;
    end
    if (num >= den) return MOIST_FULL;
    return 10'((num * 1000) / den);
  endfunction

  function automatic ctrl_status_t next_pump_status(input ctrl_item_t it);
    ctrl_status_t st;
    logic [9:0]   moist;
    bit           blocked;
    int           thr;
    moist   = '0;
    blocked = 1'b0;
    case (it.req)
      REQ_TICK: begin
        moist = tenths_from_raw(it.raw);
        if (cool_ms != 0) cool_ms = (it.dt >= cool_ms) ? 0 : cool_ms - it.dt;
        if (run_ms != 0) begin
          run_ms = (it.dt >= run_ms) ? 0 : run_ms - it.dt;
          if (run_ms == 0) begin
            pump_state = 1'b0;
            cool_ms    = live_cfg.cooldown_seconds * 1000;
          end
        end
        if (live_cfg.automation_enable && !pump_state && cool_ms == 0) begin
          // A target below the band gives a negative threshold and never starts the pump.
          thr = int'(live_cfg.moisture_target) - int'(live_cfg.hysteresis_band);
          if (int'(moist) < thr) begin
            if (it.batt < live_cfg.battery_block_mv) begin
              blocked = 1'b1;
            end else begin
              run_ms      = live_cfg.max_run_seconds * 1000;
              pump_state  = 1'b1;
              start_total = start_total + 1;
            end
          end
        end
        if (it.mark && pump_state) on_second_total = on_second_total + 1;
      end
      REQ_MANUAL_ON: begin
        run_ms  = live_cfg.max_run_seconds * 1000;
        cool_ms = 0;
        if (!pump_state) start_total = start_total + 1;
        pump_state = 1'b1;
      end
      REQ_MANUAL_OFF: begin
        run_ms     = 0;
        pump_state = 1'b0;
        cool_ms    = live_cfg.cooldown_seconds * 1000;
      end
      default: begin
      end
    endcase
    st.pump      = pump_state;
    st.moist     = moist;
    st.blocked   = blocked;
    st.run_left  = 16'(run_ms);
    st.cool_left = 18'(cool_ms);
    st.starts    = start_total;
    st.on_secs   = on_second_total;
    return st;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result checking and prediction share one process so their order is fixed.
  always @(posedge clk) begin
    if (rst) begin
      in_beat_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected, expected none, actual pump_on %0d",
                   $time, pump_on);
        end else begin
          ctrl_status_t want;
          want = status_due.pop_front();
          check_field("pump_on", want.pump, pump_on);
          check_field("moisture_tenths", want.moist, moisture_tenths);
          check_field("start_blocked", want.blocked, start_blocked);
          check_field("run_time_left", want.run_left, run_time_left);
          check_field("cooldown_time_left", want.cool_left, cooldown_time_left);
          check_field("pump_starts", want.starts, pump_starts);
          check_field("pump_on_seconds", want.on_secs, pump_on_seconds);
        end
        beats_checked++;
      end
      if (in_valid && in_ready)
        status_due.push_back(next_pump_status(ctrl_item_t'({req_type, elapsed_ms, moisture_raw,
                                                            battery_mv, second_mark})));
      in_beat_taken <= in_valid && in_ready;
    end
  end

  // Request driver: holds each beat until it is taken, then idles for a random gap.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        launch_item = item_backlog.pop_front();
        req_type     <= launch_item.req;
        elapsed_ms   <= launch_item.dt;
        moisture_raw <= launch_item.raw;
        battery_mv   <= launch_item.batt;
        second_mark  <= launch_item.mark;
        in_valid     <= 1'b1;
        if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
        tx_gap = tx_steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!backpressure_done && beats_checked >= 40) begin
        backpressure_done = 1'b1;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
        rx_hold = rx_steady ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_AUTOMATION_ENABLE: live_cfg.automation_enable = value[0];
      REG_MOISTURE_TARGET:   live_cfg.moisture_target   = value[9:0];
      REG_HYSTERESIS_BAND:   live_cfg.hysteresis_band   = value[7:0];
      REG_MAX_RUN_SECONDS:   live_cfg.max_run_seconds   = value[5:0];
      REG_COOLDOWN_SECONDS:  live_cfg.cooldown_seconds  = value[7:0];
      REG_RAW_DRY_LEVEL:     live_cfg.raw_dry_level     = value[11:0];
      REG_RAW_WET_LEVEL:     live_cfg.raw_wet_level     = value[11:0];
      REG_BATTERY_BLOCK_MV:  live_cfg.battery_block_mv  = value[12:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all_registers(input cfg_t c);
    apb_write(REG_AUTOMATION_ENABLE, 32'(c.automation_enable));
    apb_write(REG_MOISTURE_TARGET,   32'(c.moisture_target));
    apb_write(REG_HYSTERESIS_BAND,   32'(c.hysteresis_band));
    apb_write(REG_MAX_RUN_SECONDS,   32'(c.max_run_seconds));
    apb_write(REG_COOLDOWN_SECONDS,  32'(c.cooldown_seconds));
    apb_write(REG_RAW_DRY_LEVEL,     32'(c.raw_dry_level));
    apb_write(REG_RAW_WET_LEVEL,     32'(c.raw_wet_level));
    apb_write(REG_BATTERY_BLOCK_MV,  32'(c.battery_block_mv));
  endtask

  task automatic queue_item(input logic [1:0] req, input logic [15:0] dt,
                            input logic [11:0] raw, input logic [12:0] batt, input logic mark);
    item_backlog.push_back('{req: req, dt: dt, raw: raw, batt: batt, mark: mark});
  endtask

  // Mostly ticks, with timer steps that let runs and cooldowns expire, and a battery level
  // near the block threshold so both sides of it show up.
  task automatic queue_random_items(input int unsigned count);
    ctrl_item_t it;
    int unsigned r;
    int b;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) it.req = REQ_TICK;
      else if (r < 88) it.req = REQ_MANUAL_ON;
      else if (r < 96) it.req = REQ_MANUAL_OFF;
      else it.req = REQ_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 15) it.dt = '0;
      else if (r < 60) it.dt = 16'($urandom_range(1, 3000));
      else if (r < 85) it.dt = 16'($urandom_range(3001, 20000));
      else it.dt = 16'($urandom_range(0, 65535));
      it.raw = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) < 7) begin
        b = int'(live_cfg.battery_block_mv) + int'($urandom_range(0, 400)) - 200;
        if (b < 0) b = 0;
        if (b > 8191) b = 8191;
        it.batt = 13'(b);
      end else begin
        it.batt = 13'($urandom_range(0, 8191));
      end
      it.mark = 1'($urandom_range(0, 1));
      item_backlog.push_back(it);
    end
  endtask

  task automatic wait_until_drained();
    while (item_backlog.size() != 0 || in_valid || status_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: threshold 520, block level 4720.
    queue_item(REQ_TICK, 16'd0, 12'd0, 13'd0, 1'b0);
    queue_item(REQ_TICK, 16'hFFFF, 12'hFFF, 13'h1FFF, 1'b1);
    queue_item(REQ_TICK, 16'd1000, 12'd3000, 13'd4720, 1'b1);
    queue_item(REQ_TICK, 16'hFFFF, 12'd2100, 13'd4720, 1'b0);
    queue_item(REQ_TICK, 16'd24999, 12'hFFF, 13'd4719, 1'b0);
    queue_item(REQ_TICK, 16'd1, 12'hFFF, 13'd4719, 1'b0);
    queue_item(REQ_TICK, 16'd0, 12'hFFF, 13'd4720, 1'b1);
    queue_item(REQ_MANUAL_ON, 16'hFFFF, 12'hFFF, 13'h1FFF, 1'b1);
    queue_item(REQ_MANUAL_OFF, 16'h5555, 12'hAAA, 13'h0AAA, 1'b1);
    queue_item(REQ_MANUAL_ON, 16'hAAAA, 12'h555, 13'h1555, 1'b0);
    queue_item(REQ_UNUSED, 16'hFFFF, 12'hFFF, 13'h1FFF, 1'b1);
    queue_item(REQ_MANUAL_OFF, 16'd0, 12'd0, 13'd0, 1'b0);
    queue_item(REQ_UNUSED, 16'd0, 12'd0, 13'd0, 1'b0);
    queue_item(REQ_TICK, 16'd30000, 12'd1200, 13'h1FFF, 1'b1);
    queue_item(REQ_TICK, 16'd0, 12'd1199, 13'h1FFF, 1'b0);
    queue_item(REQ_TICK, 16'd0, 12'd3001, 13'd0, 1'b0);
    queue_item(REQ_TICK, 16'd0, 12'd2999, 13'd0, 1'b0);
    queue_item(REQ_TICK, 16'd0, 12'd2983, 13'd0, 1'b0);
    queue_item(REQ_MANUAL_ON, 16'd0, 12'd0, 13'd0, 1'b0);
    queue_item(REQ_TICK, 16'd17999, 12'd0, 13'd0, 1'b1);
    queue_item(REQ_TICK, 16'd1, 12'd0, 13'd0, 1'b1);
    queue_item(REQ_TICK, 16'd65535, 12'd0, 13'd8191, 1'b1);
    queue_random_items(100);
    wait_until_drained();

    for (int p = 1; p <= 6; p++) begin
      c = CFG_RESET;
      case (p)
        1: begin
          // Low extremes; the target sits below the band, so only manual runs happen.
          c = '{automation_enable: 1'b1, moisture_target: 10'd50, hysteresis_band: 8'd150,
                max_run_seconds: 6'd3, cooldown_seconds: 8'd0, raw_dry_level: 12'd0,
                raw_wet_level: 12'd4095, battery_block_mv: 13'd0};
        end
        2: begin
          c = '{automation_enable: 1'b1, moisture_target: 10'd950, hysteresis_band: 8'd10,
                max_run_seconds: 6'd60, cooldown_seconds: 8'd180, raw_dry_level: 12'd4095,
                raw_wet_level: 12'd0, battery_block_mv: 13'd8191};
        end
        3: begin
          // Equal probe levels and a zero run length: a started pump stays on until stopped.
          c = '{automation_enable: 1'b1, moisture_target: 10'd600, hysteresis_band: 8'd20,
                max_run_seconds: 6'd0, cooldown_seconds: 8'd5, raw_dry_level: 12'd2000,
                raw_wet_level: 12'd2000, battery_block_mv: 13'd3000};
        end
        4: begin
          // Values outside the nominal ranges, taken at their register widths.
          c = '{automation_enable: 1'b1, moisture_target: 10'd1023, hysteresis_band: 8'd255,
                max_run_seconds: 6'd63, cooldown_seconds: 8'd255, raw_dry_level: 12'd500,
                raw_wet_level: 12'd3500, battery_block_mv: 13'd2000};
        end
        default: begin
          c.automation_enable = (p == 5) ? 1'b0 : 1'b1;
          c.moisture_target   = 10'($urandom_range(50, 950));
          c.hysteresis_band   = 8'($urandom_range(10, 150));
          c.max_run_seconds   = 6'($urandom_range(3, 60));
          c.cooldown_seconds  = 8'($urandom_range(0, 180));
          c.raw_dry_level     = 12'($urandom_range(0, 4095));
          c.raw_wet_level     = 12'($urandom_range(0, 4095));
          c.battery_block_mv  = 13'($urandom_range(0, 8191));
        end
      endcase
      write_all_registers(c);
      queue_random_items(130);
      wait_until_drained();
    end

    repeat (20) @(negedge clk);
    if (error_count == 0 && status_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
